// ===== rtl/maf_pkg.sv =====
package maf_pkg;

    // Window and sample geometry
    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int FILL_W      = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH_W     = 9;
    localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_W       = 24;
    localparam int TIME_W      = 48;

    // Divider geometry: |sum| scaled by the fraction bits, remainder one bit wider than n
    localparam int DVD_W = SUM_W + FRAC_BITS;
    localparam int REM_W = FILL_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // Saturation limits of the mean
    localparam logic signed [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic signed [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

    // Reset value of the window depth register
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLIDE,
        S_RESUM,
        S_DIVST,
        S_DIVW,
        S_OUT
    } t_state;

endpackage

// ===== rtl/moving_average_filter.sv =====
// From acceptance, a sample goes to the divider at once while the window grows; once it
// slides, the oldest sample is subtracted first, and when the depth has changed the
// window is summed afresh. A new sample is taken only after the last mean is loaded into the output
// register; the bit-serial divider (33 steps) and the single ring read port set the pace.
// Reset (synchronous, active low) clears pointer, fill count, sum and control state
// and sets the depth to one; the sample ring is not cleared and needs no sweep.
module moving_average_filter
    import maf_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [DEPTH_W-1:0]            i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                          i_capture_start,
    input  logic [TIME_W-1:0]             i_time_offset,
    input  logic [TIME_W-1:0]             i_time_duration,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [AVG_W-1:0]       o_average_value,
    output logic [TIME_W-1:0]             o_out_offset,
    output logic [TIME_W-1:0]             o_out_duration
);

    t_state r_state, n_state;

    // Filter state
    logic [DEPTH_W-1:0]            r_depth;
    logic [ADDR_W-1:0]             r_wp;
    logic [FILL_W-1:0]             r_fill;
    logic [FILL_W-1:0]             r_nprev;
    logic signed [SUM_W-1:0]       r_sum;

    // Working registers
    logic signed [SUM_W-1:0]       r_acc;
    logic [ADDR_W-1:0]             r_raddr;
    logic [ADDR_W-1:0]             r_left;
    logic                          r_pend;
    logic [TIME_W-1:0]             r_off;
    logic [TIME_W-1:0]             r_dur;

    // Sample ring
    logic signed [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;

    // Output register
    logic                          r_out_valid;
    logic signed [AVG_W-1:0]       r_avg;
    logic [TIME_W-1:0]             r_out_off;
    logic [TIME_W-1:0]             r_out_dur;

    logic                          accept;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          div_start;
    logic                          div_done;
    logic signed [AVG_W-1:0]       div_quot;
    logic                          out_load;

    logic [ADDR_W-1:0]             wp_base;
    logic [FILL_W-1:0]             fill_base;
    logic [FILL_W-1:0]             fill_new;
    logic [FILL_W-1:0]             nprev_base;
    logic signed [SUM_W-1:0]       sum_base;
    logic [FILL_W-1:0]             depth_eff;
    logic [FILL_W-1:0]             n_new;
    logic                          is_add;
    logic                          is_slide;
    logic [ADDR_W-1:0]             slide_addr;
    logic signed [SUM_W-1:0]       smp_ext;
    logic signed [SUM_W-1:0]       rd_ext;

    assign accept  = i_valid && o_ready;
    assign smp_ext = SUM_W'(i_sample_value);
    assign rd_ext  = SUM_W'(r_rd_data);

    // Effective depth: zero reads as one, saturate at the ring size
    always_comb begin
        if (r_depth == '0) begin
            depth_eff = FILL_W'(1);
        end else if (32'(r_depth) > MAX_WINDOW) begin
            depth_eff = FILL_W'(MAX_WINDOW);
        end else begin
            depth_eff = FILL_W'(r_depth);
        end
    end

    // Capture start wipes the history before the sample goes in
    assign wp_base    = i_capture_start ? '0 : r_wp;
    assign fill_base  = i_capture_start ? '0 : r_fill;
    assign nprev_base = i_capture_start ? '0 : r_nprev;
    assign sum_base   = i_capture_start ? '0 : r_sum;

    assign fill_new = (fill_base == FILL_W'(MAX_WINDOW)) ? fill_base : fill_base + 1'b1;
    assign n_new    = (depth_eff < fill_new) ? depth_eff : fill_new;

    // Window grew by one: just add. Same size: drop the oldest. Otherwise re-sum.
    assign is_add     = {1'b0, n_new} == ({1'b0, nprev_base} + 1'b1);
    assign is_slide   = n_new == nprev_base;
    assign slide_addr = wp_base - nprev_base[ADDR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_add) begin
                        n_state = S_DIVST;
                    end else if (is_slide) begin
                        n_state = S_SLIDE;
                    end else begin
                        n_state = S_RESUM;
                    end
                end
            end
            S_SLIDE: n_state = S_DIVST;
            S_RESUM: begin
                if (r_left == '0 && !r_pend) begin
                    n_state = S_DIVST;
                end
            end
            S_DIVST: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = slide_addr;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                rd_en   = i_valid && is_slide;
            end
            S_RESUM: begin
                rd_en   = r_left != '0;
                rd_addr = r_raddr;
            end
            S_DIVST: div_start = 1'b1;
            S_OUT:   out_load  = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring: read-first, one write and one read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
        if (accept) begin
            r_ring[wp_base] <= i_sample_value;
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_depth <= i_cfg_wr_data;
        end
    end

    // Filter state and re-sum control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_nprev <= '0;
            r_sum   <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (accept) begin
                r_wp    <= wp_base + 1'b1;
                r_fill  <= fill_new;
                r_nprev <= n_new;
                r_left  <= ADDR_W'(n_new - 1'b1);
                r_pend  <= 1'b0;
            end else if (r_state == S_RESUM) begin
                if (rd_en) begin
                    r_left <= r_left - 1'b1;
                end
                r_pend <= rd_en;
            end
            if (r_state == S_DIVST) begin
                r_sum <= r_acc;
            end
        end
    end

    // Accumulator and beat fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc   <= (is_add || is_slide) ? sum_base + smp_ext : smp_ext;
            r_raddr <= wp_base - 1'b1;
            r_off   <= i_time_offset;
            r_dur   <= i_time_duration;
        end else if (r_state == S_SLIDE) begin
            r_acc <= r_acc - rd_ext;
        end else if (r_state == S_RESUM) begin
            if (rd_en) begin
                r_raddr <= r_raddr - 1'b1;
            end
            if (r_pend) begin
                r_acc <= r_acc + rd_ext;
            end
        end
    end

    maf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_nprev),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_avg     <= div_quot;
            r_out_off <= r_off;
            r_out_dur <= r_dur;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_average_value = r_avg;
    assign o_out_offset    = r_out_off;
    assign o_out_duration  = r_out_dur;

endmodule

// ===== rtl/maf_div.sv =====
module maf_div
    import maf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [FILL_W-1:0]       i_divisor,
    output logic                    o_done,
    output logic signed [AVG_W-1:0] o_quot
);

    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_q;
    logic [REM_W-1:0]  r_rem;
    logic [FILL_W-1:0] r_div;
    logic              r_neg;
    logic              r_done;

    logic [SUM_W-1:0]  mag;
    logic [REM_W-1:0]  shifted;
    logic              ge;
    logic [REM_W-1:0]  n_rem;
    logic              ovf;

    // Magnitude of the dividend; the most negative sum maps to its unsigned value
    assign mag = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : i_dividend;

    // One restoring step: bring down the next dividend bit, trial subtract
    assign shifted = {r_rem[REM_W-2:0], r_q[DVD_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign n_rem   = ge ? (shifted - {1'b0, r_div}) : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    // Sign and saturation of the quotient
    always_comb begin
        if (r_neg) begin
            ovf = (|r_q[DVD_W-1:AVG_W]) || (r_q[AVG_W-1] && (|r_q[AVG_W-2:0]));
            o_quot = ovf ? AVG_MIN : AVG_W'(-r_q[AVG_W-1:0]);
        end else begin
            ovf = |r_q[DVD_W-1:AVG_W-1];
            o_quot = ovf ? AVG_MAX : AVG_W'(r_q[AVG_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule
